// File: rtl/ppm_pkg.sv
package ppm_pkg;

  // Configuration port geometry.
  localparam int unsigned CFG_INDEX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS  = 16;

  // Register field widths.
  localparam int unsigned MODE_BITS    = 3;
  localparam int unsigned PERCENT_BITS = 7;
  localparam int unsigned CHAN_BITS    = 2;

  // Reset values of the configuration registers.
  localparam int unsigned RESET_MAX_LEVEL = 255;
  localparam int unsigned RESET_PERCENT   = 50;
  localparam int unsigned RESET_BLACK     = 0;
  localparam int unsigned RESET_WHITE     = 255;

  // Threshold rounding: (percent * max + 50) / 100, done as a shift by two
  // followed by a division by 25 through a reciprocal multiply.
  localparam int unsigned THRESH_ROUND   = 50;
  localparam int unsigned THRESH_DIVISOR = 25;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_MODE      = 3'd0,
    REG_MAX_LEVEL = 3'd1,
    REG_PERCENT   = 3'd2,
    REG_BLACK     = 3'd3,
    REG_WHITE     = 3'd4,
    REG_CHANNEL   = 3'd5
  } cfg_index_t;

  // Mapping modes.
  typedef enum logic [MODE_BITS-1:0] {
    MODE_NEGATIVE   = 3'd0,
    MODE_THRESHOLD  = 3'd1,
    MODE_HALF_BLACK = 3'd2,
    MODE_HALF_WHITE = 3'd3,
    MODE_LEVELS     = 3'd4
  } mode_t;

  // Sideband that travels with a request through the divider.
  typedef struct packed {
    logic last;
    logic use_q;
  } side_t;

endpackage

// File: rtl/pixel_point_mapper_top.sv
// Pixel point mapper: maps each image sample to a new level under the
// configured mode (negative, threshold, half-threshold to black or white,
// level change) for the selected colour channel; other samples pass through.
//
// Input channel: in_valid / in_stall with sample_value, sample_channel and
// last_sample. A request is taken on a clock edge with in_valid high and
// in_stall low. Output channel: out_valid / out_stall with result_value and
// last_out, one result per sample, in order.
// Configuration: cfg_wr_en, cfg_index, cfg_data; write only while idle.
//
// Throughput is one sample per cycle while the receiver does not stall.
// The pipeline has four front stages for the compares and products, one
// stage per quotient bit in the level change divider, and the output
// register. When the receiver stalls, empty stages still fill, so in_stall
// rises only once every stage holds a request. Synchronous reset empties
// the pipeline and loads the register defaults.
module pixel_point_mapper_top #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [SAMPLE_BITS-1:0]            sample_value,
  input  logic [ppm_pkg::CHAN_BITS-1:0]     sample_channel,
  input  logic                              last_sample,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [SAMPLE_BITS-1:0]            result_value,
  output logic                              last_out,
  input  logic                              cfg_wr_en,
  input  logic [ppm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [ppm_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  localparam int unsigned SB = SAMPLE_BITS;

  logic [ppm_pkg::MODE_BITS-1:0]    mode;
  logic [SB-1:0]                    max_level;
  logic [ppm_pkg::PERCENT_BITS-1:0] threshold_percent;
  logic [SB-1:0]                    black_level;
  logic [SB-1:0]                    white_level;
  logic [ppm_pkg::CHAN_BITS-1:0]    channel_select;

  logic                             front_ready;
  logic                             front_valid;
  logic [2*SB:0]                    front_num;
  logic [SB:0]                      front_den;
  logic [SB-1:0]                    front_base;
  ppm_pkg::side_t                   front_side;

  logic                             div_ready;
  logic                             div_valid;
  logic [SB-1:0]                    div_q;
  logic [SB-1:0]                    div_base;
  ppm_pkg::side_t                   div_side;
  logic                             out_en;

  ppm_cfg #(.SAMPLE_BITS(SB)) u_cfg (
    .clk               (clk),
    .rst               (rst),
    .wr_en             (cfg_wr_en),
    .index             (cfg_index),
    .data              (cfg_data),
    .mode              (mode),
    .max_level         (max_level),
    .threshold_percent (threshold_percent),
    .black_level       (black_level),
    .white_level       (white_level),
    .channel_select    (channel_select)
  );

  ppm_front #(.SAMPLE_BITS(SB)) u_front (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (front_ready),
    .sample_value      (sample_value),
    .sample_channel    (sample_channel),
    .last_sample       (last_sample),
    .mode              (mode),
    .max_level         (max_level),
    .threshold_percent (threshold_percent),
    .black_level       (black_level),
    .white_level       (white_level),
    .channel_select    (channel_select),
    .out_valid         (front_valid),
    .out_ready         (div_ready),
    .num               (front_num),
    .den               (front_den),
    .base              (front_base),
    .side              (front_side)
  );

  ppm_div #(.SAMPLE_BITS(SB)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (div_ready),
    .num       (front_num),
    .den       (front_den),
    .base      (front_base),
    .side      (front_side),
    .out_valid (div_valid),
    .out_ready (out_en),
    .q         (div_q),
    .out_base  (div_base),
    .out_side  (div_side)
  );

  assign in_stall = !front_ready;
  assign out_en   = !out_valid || !out_stall;

  // Output register: the quotient replaces the base value inside the
  // level window.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_en) begin
      out_valid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      result_value <= div_side.use_q ? div_q : div_base;
      last_out     <= div_side.last;
    end
  end

  // The input side can only be held off once the output is full and stalled.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the output stage could move");

  // A new result appears only when the divider held one the cycle before.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(div_valid))
    else $error("result presented without a request from the divider");

endmodule

// File: rtl/ppm_cfg.sv
module ppm_cfg #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  wr_en,
  input  logic [ppm_pkg::CFG_INDEX_BITS-1:0]    index,
  input  logic [ppm_pkg::CFG_DATA_BITS-1:0]     data,
  output logic [ppm_pkg::MODE_BITS-1:0]         mode,
  output logic [SAMPLE_BITS-1:0]                max_level,
  output logic [ppm_pkg::PERCENT_BITS-1:0]      threshold_percent,
  output logic [SAMPLE_BITS-1:0]                black_level,
  output logic [SAMPLE_BITS-1:0]                white_level,
  output logic [ppm_pkg::CHAN_BITS-1:0]         channel_select
);

  // Register file: one write per cycle, levels kept in the sample width.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode              <= ppm_pkg::MODE_NEGATIVE;
      max_level         <= SAMPLE_BITS'(ppm_pkg::RESET_MAX_LEVEL);
      threshold_percent <= ppm_pkg::PERCENT_BITS'(ppm_pkg::RESET_PERCENT);
      black_level       <= SAMPLE_BITS'(ppm_pkg::RESET_BLACK);
      white_level       <= SAMPLE_BITS'(ppm_pkg::RESET_WHITE);
      channel_select    <= '0;
    end else if (wr_en) begin
      case (ppm_pkg::cfg_index_t'(index))
        ppm_pkg::REG_MODE:      mode              <= data[ppm_pkg::MODE_BITS-1:0];
        ppm_pkg::REG_MAX_LEVEL: max_level         <= data[SAMPLE_BITS-1:0];
        ppm_pkg::REG_PERCENT:   threshold_percent <= data[ppm_pkg::PERCENT_BITS-1:0];
        ppm_pkg::REG_BLACK:     black_level       <= data[SAMPLE_BITS-1:0];
        ppm_pkg::REG_WHITE:     white_level       <= data[SAMPLE_BITS-1:0];
        ppm_pkg::REG_CHANNEL:   channel_select    <= data[ppm_pkg::CHAN_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/ppm_front.sv
module ppm_front #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [SAMPLE_BITS-1:0]             sample_value,
  input  logic [ppm_pkg::CHAN_BITS-1:0]      sample_channel,
  input  logic                               last_sample,
  input  logic [ppm_pkg::MODE_BITS-1:0]      mode,
  input  logic [SAMPLE_BITS-1:0]             max_level,
  input  logic [ppm_pkg::PERCENT_BITS-1:0]   threshold_percent,
  input  logic [SAMPLE_BITS-1:0]             black_level,
  input  logic [SAMPLE_BITS-1:0]             white_level,
  input  logic [ppm_pkg::CHAN_BITS-1:0]      channel_select,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [2*SAMPLE_BITS:0]             num,
  output logic [SAMPLE_BITS:0]               den,
  output logic [SAMPLE_BITS-1:0]             base,
  output ppm_pkg::side_t                     side
);

  localparam int unsigned SB  = SAMPLE_BITS;
  localparam int unsigned PMW = SB + 7;          // percent * max, rounding added
  localparam int unsigned YW  = SB + 5;          // (percent * max + 50) >> 2
  localparam int unsigned RK  = SB + 10;         // reciprocal shift
  localparam int unsigned MW  = SB + 6;          // reciprocal width
  localparam int unsigned TPW = YW + MW;         // reciprocal product width
  localparam longint unsigned RM =
    ((64'd1 << RK) + ppm_pkg::THRESH_DIVISOR - 1) / ppm_pkg::THRESH_DIVISOR;
  localparam logic [MW-1:0] RM_V = MW'(RM);

  logic                  v1, v2, v3;
  logic                  en1, en2, en3, en4;
  logic [SB-1:0]         s1, s2, s3;
  logic                  last1, last2, last3;
  logic                  hit1, hit2, hit3;
  logic                  le1, le2, le3;
  logic                  ge1, ge2, ge3;
  logic [SB-1:0]         diff1;
  logic [PMW-1:0]        pm1;
  logic [PMW-1:0]        pm_sum;
  logic [2*SB-1:0]       prod2;
  logic [YW-1:0]         y2;
  logic [TPW-1:0]        tprod3;
  logic [2*SB:0]         num3;
  logic [SB-1:0]         span;
  logic [SB:0]           thresh;
  logic [SB:0]           s3x;
  logic                  hit_in;
  logic [SB-1:0]         base_next;
  logic                  use_q_next;

  // A stage moves when it is empty or the stage after it moves.
  assign en4      = !out_valid || out_ready;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  // Channel selection: zero takes every sample, otherwise one colour only.
  assign hit_in = (channel_select == '0) ||
                  (sample_channel == channel_select - ppm_pkg::CHAN_BITS'(1));

  assign span = white_level - black_level;
  assign den  = {span, 1'b0};

  // Stage 1: level window compares, offset from black and the threshold product.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1    <= sample_value;
      last1 <= last_sample;
      hit1  <= hit_in;
      le1   <= sample_value <= black_level;
      ge1   <= sample_value >= white_level;
      diff1 <= sample_value - black_level;
      pm1   <= PMW'(threshold_percent) * PMW'(max_level);
    end
  end

  // Stage 2: rescale product and the rounded, pre-shifted threshold term.
  assign pm_sum = pm1 + PMW'(ppm_pkg::THRESH_ROUND);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2    <= s1;
      last2 <= last1;
      hit2  <= hit1;
      le2   <= le1;
      ge2   <= ge1;
      prod2 <= (2*SB)'(diff1) * (2*SB)'(max_level);
      y2    <= pm_sum[PMW-1:2];
    end
  end

  // Stage 3: reciprocal multiply for the division by 25, and the dividend.
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3     <= s2;
      last3  <= last2;
      hit3   <= hit2;
      le3    <= le2;
      ge3    <= ge2;
      tprod3 <= TPW'(y2) * TPW'(RM_V);
      num3   <= {prod2, 1'b0} + (2*SB+1)'(span);
    end
  end

  // Stage 4: mode selection; only the interior of the level window needs
  // the quotient from the divider.
  assign thresh = tprod3[TPW-1:RK];
  assign s3x    = {1'b0, s3};

  always_comb begin
    base_next  = s3;
    use_q_next = 1'b0;
    if (hit3) begin
      case (ppm_pkg::mode_t'(mode))
        ppm_pkg::MODE_NEGATIVE:   base_next = (s3 > max_level) ? '0 : max_level - s3;
        ppm_pkg::MODE_THRESHOLD:  base_next = (s3x > thresh) ? max_level : '0;
        ppm_pkg::MODE_HALF_BLACK: base_next = (s3x <= thresh) ? '0 : s3;
        ppm_pkg::MODE_HALF_WHITE: base_next = (s3x > thresh) ? max_level : s3;
        ppm_pkg::MODE_LEVELS: begin
          base_next  = le3 ? '0 : max_level;
          use_q_next = !le3 && !ge3;
        end
        default: base_next = s3;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en4) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      num        <= num3;
      base       <= base_next;
      side.last  <= last3;
      side.use_q <= use_q_next;
    end
  end

endmodule

// File: rtl/ppm_div.sv
module ppm_div #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2*SAMPLE_BITS:0]   num,
  input  logic [SAMPLE_BITS:0]     den,
  input  logic [SAMPLE_BITS-1:0]   base,
  input  ppm_pkg::side_t           side,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [SAMPLE_BITS-1:0]   q,
  output logic [SAMPLE_BITS-1:0]   out_base,
  output ppm_pkg::side_t           out_side
);

  localparam int unsigned SB = SAMPLE_BITS;

  // One restoring step per stage, most significant quotient bit first.
  // The quotient is known to fit in SB bits, so the partial remainder
  // starts from the upper half of the dividend.
  logic           v   [SB];
  logic           en  [SB];
  logic [SB:0]    rem [SB];
  logic [SB-1:0]  low [SB];
  logic [SB-1:0]  qr  [SB];
  logic [SB-1:0]  bs  [SB];
  ppm_pkg::side_t sd  [SB];

  for (genvar j = 0; j < SB; j++) begin : g_stage
    logic           p_v;
    logic [SB:0]    p_rem;
    logic [SB-1:0]  p_low;
    logic [SB-1:0]  p_q;
    logic [SB-1:0]  p_bs;
    ppm_pkg::side_t p_sd;
    logic [SB+1:0]  trial;
    logic [SB+1:0]  diff;
    logic           take;

    // Source of this stage: the input port or the stage before.
    if (j == 0) begin : g_src_in
      assign p_v   = in_valid;
      assign p_rem = num[2*SB:SB];
      assign p_low = num[SB-1:0];
      assign p_q   = '0;
      assign p_bs  = base;
      assign p_sd  = side;
    end else begin : g_src_prev
      assign p_v   = v[j-1];
      assign p_rem = rem[j-1];
      assign p_low = low[j-1];
      assign p_q   = qr[j-1];
      assign p_bs  = bs[j-1];
      assign p_sd  = sd[j-1];
    end

    // Handshake chain towards the output.
    if (j == SB - 1) begin : g_en_last
      assign en[j] = !v[j] || out_ready;
    end else begin : g_en_mid
      assign en[j] = !v[j] || en[j+1];
    end

    assign trial = {p_rem, p_low[SB-1]};
    assign diff  = trial - {1'b0, den};
    assign take  = trial >= {1'b0, den};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j] <= 1'b0;
      end else if (en[j]) begin
        v[j] <= p_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        rem[j] <= take ? diff[SB:0] : trial[SB:0];
        low[j] <= {p_low[SB-2:0], 1'b0};
        qr[j]  <= {p_q[SB-2:0], take};
        bs[j]  <= p_bs;
        sd[j]  <= p_sd;
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[SB-1];
  assign q         = qr[SB-1];
  assign out_base  = bs[SB-1];
  assign out_side  = sd[SB-1];

endmodule

// File: test/tb_pixel_point_mapper_top.sv
`timescale 1ns / 1ps

module tb_pixel_point_mapper_top;

  localparam int SAMPLE_BITS   = 16;
  localparam int LATENCY       = SAMPLE_BITS + 5;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 120;
  localparam int STALL_LIMIT   = 3000;
  localparam int PHASES        = 29;
  localparam int PER_PHASE     = 50;

  // Register settings as seen by the mapper.
  typedef struct {
    logic [ppm_pkg::MODE_BITS-1:0]    mode;
    logic [15:0]                      max_level;
    logic [ppm_pkg::PERCENT_BITS-1:0] percent;
    logic [15:0]                      black;
    logic [15:0]                      white;
    logic [ppm_pkg::CHAN_BITS-1:0]    chan_sel;
  } map_cfg_t;

  // One mapped sample as it leaves the block.
  typedef struct packed {
    logic [15:0] value;
    logic        is_last;
  } mapped_t;

  // One row of the directed table: a register change or a sample.
  typedef struct {
    bit                  is_cfg;
    ppm_pkg::cfg_index_t idx;
    logic [15:0]         data;
    logic [15:0]         value;
    logic [1:0]          chan;
    logic                is_last;
    bit                  typed;
    logic [15:0]         want;
  } step_t;

  logic                               clk;
  logic                               rst = 1'b1;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic [SAMPLE_BITS-1:0]             sample_value = '0;
  logic [ppm_pkg::CHAN_BITS-1:0]      sample_channel = '0;
  logic                               last_sample = 1'b0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic [SAMPLE_BITS-1:0]             result_value;
  logic                               last_out;
  logic                               cfg_wr_en = 1'b0;
  logic [ppm_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [ppm_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;

  mapped_t  mapped_due[$];
  map_cfg_t active_cfg;
  bit       calm = 1'b0;
  bit       hold_req = 1'b0;
  int       mismatch_count = 0;
  int       results_checked = 0;
  int       samples_sent = 0;
  int       settings_loaded = 0;
  int       holds_done = 0;

  pixel_point_mapper_top #(.SAMPLE_BITS(SAMPLE_BITS)) u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .sample_value   (sample_value),
    .sample_channel (sample_channel),
    .last_sample    (last_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .result_value   (result_value),
    .last_out       (last_out),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Threshold level: percent of the maximum level, halves rounded up.
  function automatic logic [31:0] thresh_of(input map_cfg_t c);
    logic [31:0] pct;
    logic [31:0] mx;
    pct = 32'(c.percent);
    mx  = 32'(c.max_level);
    return (pct * mx + 32'd50) / 32'd100;
  endfunction

  // Expected output for one sample under the given settings.
  function automatic mapped_t map_sample(input map_cfg_t c, input logic [15:0] v,
                                         input logic [1:0] ch, input logic is_last);
    logic [31:0] level;
    logic [31:0] v32;
    logic [63:0] sv, bl, wl, mx, span, num;
    logic [15:0] r;
    int          chi, sel;
    bit          hit;
    mapped_t     m;
    level = thresh_of(c);
    v32   = 32'(v);
    chi   = int'(ch);
    sel   = int'(c.chan_sel);
    hit   = (sel == 0) || (chi < 3 && ((chi + 1) % 3) == (sel % 3));
    r     = v;
    if (hit) begin
      case (c.mode)
        ppm_pkg::MODE_NEGATIVE:   r = (v > c.max_level) ? 16'd0 : c.max_level - v;
        ppm_pkg::MODE_THRESHOLD:  r = (v32 > level) ? c.max_level : 16'd0;
        ppm_pkg::MODE_HALF_BLACK: r = (v32 <= level) ? 16'd0 : v;
        ppm_pkg::MODE_HALF_WHITE: r = (v32 > level) ? c.max_level : v;
        ppm_pkg::MODE_LEVELS: begin
          if (v <= c.black) begin
            r = 16'd0;
          end else if (v >= c.white) begin
            r = c.max_level;
          end else begin
            sv   = 64'(v);
            bl   = 64'(c.black);
            wl   = 64'(c.white);
            mx   = 64'(c.max_level);
            span = wl - bl;
            num  = 64'd2 * (sv - bl) * mx + span;
            r    = 16'(num / (64'd2 * span));
          end
        end
        default: r = v;
      endcase
    end
    m.value   = r;
    m.is_last = is_last;
    return m;
  endfunction

  // Length of an idle or stall stretch: mostly short, now and then long.
  function automatic int stretch_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 90) return $urandom_range(3, 6);
    return $urandom_range(15, 40);
  endfunction

  // Random sample level, weighted towards the interesting points of the setting.
  function automatic logic [15:0] pick_sample(input map_cfg_t c);
    int r, base;
    r = $urandom_range(0, 9);
    case (r)
      6: begin
        case ($urandom_range(0, 2))
          0: base = int'(thresh_of(c));
          1: base = int'(c.black);
          default: base = int'(c.white);
        endcase
        base = base + int'($urandom_range(0, 4)) - 2;
        if (base < 0) base = 0;
        if (base > 65535) base = 65535;
        return 16'(base);
      end
      7: return 16'($urandom());
      8: begin
        case ($urandom_range(0, 3))
          0: return 16'd0;
          1: return c.max_level;
          2: return 16'hFFFF;
          default: return c.max_level + 16'd1;
        endcase
      end
      default: return 16'($urandom_range(0, c.max_level));
    endcase
  endfunction

  function automatic step_t cfg_row(input ppm_pkg::cfg_index_t idx, input int data);
    step_t s;
    s.is_cfg  = 1'b1;
    s.idx     = idx;
    s.data    = 16'(data);
    s.value   = '0;
    s.chan    = '0;
    s.is_last = 1'b0;
    s.typed   = 1'b0;
    s.want    = '0;
    return s;
  endfunction

  function automatic step_t smp_row(input int v, input int ch, input bit is_last,
                                    input bit typed, input int want);
    step_t s;
    s.is_cfg  = 1'b0;
    s.idx     = ppm_pkg::REG_MODE;
    s.data    = '0;
    s.value   = 16'(v);
    s.chan    = 2'(ch);
    s.is_last = is_last;
    s.typed   = typed;
    s.want    = 16'(want);
    return s;
  endfunction

  // Drop the request line and wait until every result is back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (mapped_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write all six registers once the mapper has drained.
  task automatic load_config(input map_cfg_t c);
    ppm_pkg::cfg_index_t idx;
    logic [15:0]         word;
    wait_idle();
    for (int i = 0; i <= ppm_pkg::REG_CHANNEL; i++) begin
      idx = ppm_pkg::cfg_index_t'(i);
      case (idx)
        ppm_pkg::REG_MODE:      word = 16'(c.mode);
        ppm_pkg::REG_MAX_LEVEL: word = c.max_level;
        ppm_pkg::REG_PERCENT:   word = 16'(c.percent);
        ppm_pkg::REG_BLACK:     word = c.black;
        ppm_pkg::REG_WHITE:     word = c.white;
        default:                word = 16'(c.chan_sel);
      endcase
      cfg_wr_en <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= word;
      @(negedge clk);
    end
    cfg_wr_en <= 1'b0;
    active_cfg = c;
    settings_loaded++;
  endtask

  // Offer one request and record its expected result once it is taken.
  task automatic send_sample(input logic [15:0] v, input logic [1:0] ch, input logic is_last,
                             input bit typed, input logic [15:0] want);
    int      gap;
    mapped_t m;
    gap = (calm || $urandom_range(0, 9) > 2) ? 0 : stretch_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    sample_value   <= v;
    sample_channel <= ch;
    last_sample    <= is_last;
    do @(posedge clk); while (in_stall);
    m = map_sample(active_cfg, v, ch, is_last);
    if (typed) m.value = want;
    mapped_due.push_back(m);
    samples_sent++;
    @(negedge clk);
  endtask

  // Stimulus: directed table, then random settings with random samples.
  initial begin
    step_t    steps[$];
    map_cfg_t pend;
    bit       dirty;
    int       directed_count;
    int       pick;
    int       total_bad;

    pend = '{mode: ppm_pkg::MODE_NEGATIVE,
             max_level: 16'(ppm_pkg::RESET_MAX_LEVEL),
             percent: ppm_pkg::PERCENT_BITS'(ppm_pkg::RESET_PERCENT),
             black: 16'(ppm_pkg::RESET_BLACK),
             white: 16'(ppm_pkg::RESET_WHITE),
             chan_sel: '0};
    active_cfg = pend;
    dirty = 1'b0;

    // Reset defaults: negative of 255, floored at zero above the maximum level.
    steps.push_back(smp_row(0, 0, 0, 1, 255));
    steps.push_back(smp_row(255, 1, 0, 1, 0));
    steps.push_back(smp_row(300, 2, 0, 1, 0));
    steps.push_back(smp_row(65535, 3, 1, 1, 0));
    // Threshold at 50 percent of 255 sits at 128.
    steps.push_back(cfg_row(ppm_pkg::REG_MODE, ppm_pkg::MODE_THRESHOLD));
    steps.push_back(smp_row(128, 0, 0, 1, 0));
    steps.push_back(smp_row(129, 1, 0, 1, 255));
    steps.push_back(cfg_row(ppm_pkg::REG_MODE, ppm_pkg::MODE_HALF_BLACK));
    steps.push_back(smp_row(128, 2, 0, 1, 0));
    steps.push_back(smp_row(129, 0, 0, 1, 129));
    steps.push_back(cfg_row(ppm_pkg::REG_MODE, ppm_pkg::MODE_HALF_WHITE));
    steps.push_back(smp_row(128, 1, 0, 1, 128));
    steps.push_back(smp_row(129, 2, 0, 1, 255));
    // Level change between 16 and 240.
    steps.push_back(cfg_row(ppm_pkg::REG_MODE, ppm_pkg::MODE_LEVELS));
    steps.push_back(cfg_row(ppm_pkg::REG_BLACK, 16));
    steps.push_back(cfg_row(ppm_pkg::REG_WHITE, 240));
    steps.push_back(smp_row(16, 0, 0, 1, 0));
    steps.push_back(smp_row(240, 0, 0, 1, 255));
    steps.push_back(smp_row(128, 1, 0, 0, 0));
    steps.push_back(smp_row(17, 2, 0, 0, 0));
    // An undefined mode passes the sample through.
    steps.push_back(cfg_row(ppm_pkg::REG_MODE, 7));
    steps.push_back(smp_row(77, 0, 0, 1, 77));
    // Single channel selection; channel code 3 is never a colour.
    steps.push_back(cfg_row(ppm_pkg::REG_MODE, ppm_pkg::MODE_NEGATIVE));
    steps.push_back(cfg_row(ppm_pkg::REG_CHANNEL, 2));
    steps.push_back(smp_row(10, 1, 0, 1, 245));
    steps.push_back(smp_row(10, 0, 0, 1, 10));
    steps.push_back(smp_row(10, 3, 0, 1, 10));
    steps.push_back(cfg_row(ppm_pkg::REG_CHANNEL, 3));
    steps.push_back(smp_row(10, 2, 0, 1, 245));
    steps.push_back(smp_row(10, 3, 1, 1, 10));
    // Full-scale maximum level with threshold at 100, 127 and 0 percent.
    steps.push_back(cfg_row(ppm_pkg::REG_CHANNEL, 0));
    steps.push_back(cfg_row(ppm_pkg::REG_MAX_LEVEL, 65535));
    steps.push_back(cfg_row(ppm_pkg::REG_PERCENT, 100));
    steps.push_back(cfg_row(ppm_pkg::REG_MODE, ppm_pkg::MODE_THRESHOLD));
    steps.push_back(smp_row(65535, 0, 0, 1, 0));
    steps.push_back(cfg_row(ppm_pkg::REG_PERCENT, 127));
    steps.push_back(smp_row(65535, 1, 0, 1, 0));
    steps.push_back(cfg_row(ppm_pkg::REG_PERCENT, 0));
    steps.push_back(smp_row(0, 2, 0, 1, 0));
    steps.push_back(smp_row(1, 0, 0, 1, 65535));
    // White not above black: only the two clamps can be reached.
    steps.push_back(cfg_row(ppm_pkg::REG_MODE, ppm_pkg::MODE_LEVELS));
    steps.push_back(cfg_row(ppm_pkg::REG_BLACK, 100));
    steps.push_back(cfg_row(ppm_pkg::REG_WHITE, 100));
    steps.push_back(smp_row(100, 0, 0, 1, 0));
    steps.push_back(smp_row(101, 1, 1, 1, 65535));

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Walk the directed table; register changes are gathered and written before a sample.
    foreach (steps[i]) begin
      if (steps[i].is_cfg) begin
        case (steps[i].idx)
          ppm_pkg::REG_MODE:      pend.mode      = steps[i].data[ppm_pkg::MODE_BITS-1:0];
          ppm_pkg::REG_MAX_LEVEL: pend.max_level = steps[i].data;
          ppm_pkg::REG_PERCENT:   pend.percent   = steps[i].data[ppm_pkg::PERCENT_BITS-1:0];
          ppm_pkg::REG_BLACK:     pend.black     = steps[i].data;
          ppm_pkg::REG_WHITE:     pend.white     = steps[i].data;
          default:                pend.chan_sel  = steps[i].data[ppm_pkg::CHAN_BITS-1:0];
        endcase
        dirty = 1'b1;
      end else begin
        if (dirty) load_config(pend);
        dirty = 1'b0;
        send_sample(steps[i].value, steps[i].chan, steps[i].is_last,
                    steps[i].typed, steps[i].want);
      end
    end
    directed_count = samples_sent;

    // Random phases, each with its own register setting.
    for (int p = 0; p < PHASES; p++) begin
      pend.mode = ($urandom_range(0, 99) < 90) ?
                  3'($urandom_range(ppm_pkg::MODE_NEGATIVE, ppm_pkg::MODE_LEVELS)) :
                  3'($urandom_range(ppm_pkg::MODE_LEVELS + 1, 7));
      pick = $urandom_range(0, 4);
      case (pick)
        0: pend.max_level = 16'hFFFF;
        1: pend.max_level = 16'd255;
        2: pend.max_level = 16'($urandom_range(1, 65535));
        3: pend.max_level = 16'($urandom_range(1, 1023));
        default: pend.max_level = (p % 2 == 0) ? 16'd1 : 16'($urandom_range(1, 65535));
      endcase
      pick = $urandom_range(0, 9);
      if (pick == 0) pend.percent = 7'd0;
      else if (pick == 1) pend.percent = 7'd100;
      else if (pick == 2) pend.percent = 7'($urandom_range(101, 127));
      else pend.percent = 7'($urandom_range(0, 100));
      pend.black = 16'($urandom_range(0, pend.max_level));
      pend.white = 16'($urandom_range(0, pend.max_level));
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        pend.black = 16'd0;
        pend.white = pend.max_level;
      end else if (pick < 8 && pend.black > pend.white) begin
        {pend.black, pend.white} = {pend.white, pend.black};
      end else if (pick == 9) begin
        pend.black = 16'($urandom());
        pend.white = 16'($urandom());
      end
      pend.chan_sel = 2'($urandom_range(0, 3));
      load_config(pend);

      // Some phases run flat out; one of them also holds the receiver off.
      calm = (p % 6 == 4) || (p == 2);
      if (p == 2) hold_req = 1'b1;
      for (int k = 0; k < PER_PHASE; k++) begin
        send_sample(pick_sample(active_cfg),
                    ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2)),
                    ($urandom_range(0, 15) == 0), 1'b0, '0);
      end
      calm = 1'b0;
    end

    // Drain and finish.
    in_valid <= 1'b0;
    while (mapped_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    total_bad = mismatch_count + mapped_due.size();
    $display("Covered %0d directed and %0d random samples over %0d register settings.",
             directed_count, samples_sent - directed_count, settings_loaded);
    $display("Checked %0d results, %0d long receiver hold-off(s), %0d mismatches.",
             results_checked, holds_done, total_bad);
    if (total_bad == 0) begin
      $display("pixel_point_mapper_top test passed");
    end else begin
      $display("pixel_point_mapper_top test failed");
    end
    $finish;
  end

  // Receiver stall pattern, with one long hold-off when asked for.
  initial begin
    int run_left;
    bit stalling;
    run_left = 0;
    stalling = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && holds_done == 0) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_done++;
      end
      if (run_left == 0) begin
        stalling = !calm && ($urandom_range(0, 2) == 0);
        run_left = stalling ? stretch_len() : $urandom_range(1, 8);
      end
      run_left--;
      out_stall <= stalling && !calm;
    end
  end

  // Result checking and the no-progress watchdog.
  initial begin
    int      idle_cycles;
    mapped_t m;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (mapped_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: value %0d last %0b", result_value, last_out);
        end else begin
          m = mapped_due.pop_front();
          if (result_value !== m.value || last_out !== m.is_last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch on result %0d: expected value %0d last %0b, got %0d last %0b",
                       results_checked, m.value, m.is_last, result_value, last_out);
          end
          results_checked++;
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("no request moved for %0d cycles, %0d results outstanding",
                 idle_cycles, mapped_due.size());
        $display("pixel_point_mapper_top test failed");
        $finish;
      end
    end
  end

endmodule

// File: pixel_point_mapper_top.f
rtl/ppm_pkg.sv
rtl/ppm_cfg.sv
rtl/ppm_front.sv
rtl/ppm_div.sv
rtl/pixel_point_mapper_top.sv
test/tb_pixel_point_mapper_top.sv
